[src/ocfb_pkg.sv]
// shared types, constants and font tables of the column framebuffer blitter
package ocfb_pkg;

    localparam int SCREEN_COLUMNS = 128;
    localparam int SCREEN_PAGES   = 4;
    localparam int ADDR_W         = $clog2(SCREEN_COLUMNS);

    localparam int CMD_W    = 3;
    localparam int COLUMN_W = 8;
    localparam int SHIFT_W  = 5;
    localparam int WORD_W   = 32;
    localparam int GLYPH_W  = 8;
    localparam int PAGE_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int ROM_IDX_W = 8;
    localparam int GLYPH_ROW_W = 5;

    localparam logic [CMD_W-1:0] CMD_FILL    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SPRITE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MASKED  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIGIT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LETTER  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SETPOS  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SCAN    = 3'd6;

    localparam logic [BYTE_W-1:0] SETPAGE_BASE = 8'hB0;
    localparam logic [BYTE_W-1:0] COLHI_BASE   = 8'h10;
    localparam logic [GLYPH_ROW_W-1:0] GLYPH_MASK = 5'h1F;
    localparam logic [2:0] DIGIT_COLS  = 3'd3;
    localparam logic [2:0] LETTER_COLS = 3'd5;

    typedef enum logic [2:0]
    {
        K_NONE,
        K_FILL,
        K_MERGE,
        K_GLYPH,
        K_POS,
        K_SCAN
    } kind_t;

    typedef struct packed
    {
        kind_t                  kind;
        logic [COLUMN_W-1:0]    column;
        logic [PAGE_W-1:0]      page;
        logic [SHIFT_W-1:0]     shift;
        logic [WORD_W-1:0]      bits;
        logic [WORD_W-1:0]      clear;
        logic                   letter;
        logic [ROM_IDX_W-1:0]   rom_base;
    } task_t;

    typedef struct packed
    {
        logic [BYTE_W-1:0] out_byte;
        logic              is_data;
        logic              last;
    } result_t;

    localparam logic [GLYPH_ROW_W-1:0] DIGIT_ROM [0:29] = '{
        5'h0E, 5'h11, 5'h0E, 5'h02, 5'h1F, 5'h00, 5'h12, 5'h19, 5'h16, 5'h11,
        5'h15, 5'h0A, 5'h07, 5'h04, 5'h1F, 5'h17, 5'h15, 5'h09, 5'h0E, 5'h15,
        5'h08, 5'h01, 5'h19, 5'h07, 5'h0A, 5'h15, 5'h0A, 5'h02, 5'h15, 5'h0E
    };

    localparam logic [GLYPH_ROW_W-1:0] LETTER_ROM [0:129] = '{
        5'h1C, 5'h0A, 5'h09, 5'h0A, 5'h1C, 5'h1F, 5'h15, 5'h15, 5'h15, 5'h0A,
        5'h0E, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h1F, 5'h11, 5'h11, 5'h11, 5'h0E,
        5'h1F, 5'h15, 5'h15, 5'h15, 5'h11, 5'h1F, 5'h05, 5'h05, 5'h05, 5'h01,
        5'h0E, 5'h11, 5'h11, 5'h15, 5'h0D, 5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F,
        5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h08, 5'h10, 5'h11, 5'h0F, 5'h01,
        5'h1F, 5'h04, 5'h04, 5'h0A, 5'h11, 5'h1F, 5'h10, 5'h10, 5'h10, 5'h10,
        5'h1F, 5'h01, 5'h02, 5'h01, 5'h1F, 5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F,
        5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h1F, 5'h05, 5'h05, 5'h05, 5'h02,
        5'h0E, 5'h11, 5'h11, 5'h09, 5'h16, 5'h1F, 5'h05, 5'h05, 5'h05, 5'h1A,
        5'h12, 5'h15, 5'h15, 5'h15, 5'h09, 5'h01, 5'h01, 5'h1F, 5'h01, 5'h01,
        5'h0F, 5'h10, 5'h10, 5'h10, 5'h0F, 5'h03, 5'h0C, 5'h10, 5'h0C, 5'h03,
        5'h0F, 5'h10, 5'h08, 5'h10, 5'h0F, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11,
        5'h01, 5'h02, 5'h1C, 5'h02, 5'h01, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11
    };

    function automatic logic [GLYPH_ROW_W-1:0] glyph_column(
        input logic                 letter,
        input logic [ROM_IDX_W-1:0] idx
    );
        logic [GLYPH_ROW_W-1:0] row;
        if (letter)
        begin
            row = LETTER_ROM[idx];
        end
        else
        begin
            row = DIGIT_ROM[idx[4:0]];
        end
        return row;
    endfunction

endpackage

[src/ocfb_ram.sv]
// generic single write, single read ram with registered read data
module ocfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/ocfb_front.sv]
// command decoder: classifies a command and prepares shifted words and font index
module ocfb_front (
    input  logic [ocfb_pkg::CMD_W-1:0]    command,
    input  logic [ocfb_pkg::COLUMN_W-1:0] column,
    input  logic [ocfb_pkg::SHIFT_W-1:0]  shift,
    input  logic [ocfb_pkg::WORD_W-1:0]   pixels,
    input  logic [ocfb_pkg::WORD_W-1:0]   mask,
    input  logic [ocfb_pkg::GLYPH_W-1:0]  glyph,
    input  logic [ocfb_pkg::PAGE_W-1:0]   page,
    output ocfb_pkg::task_t               task_out
);

    import ocfb_pkg::*;

    logic [15:0]          prod10;
    logic [15:0]          prod26;
    logic [GLYPH_W-1:0]   rem10_raw;
    logic [GLYPH_W-1:0]   rem26_raw;
    logic [GLYPH_W-1:0]   rem10;
    logic [GLYPH_W-1:0]   rem26;
    logic [WORD_W-1:0]    pix_shifted;
    logic [WORD_W-1:0]    mask_shifted;

    // reciprocal multiply for the quotient, one correction step on the remainder
    assign prod10    = 16'(glyph) * 16'd205;
    assign prod26    = 16'(glyph) * 16'd79;
    assign rem10_raw = glyph - 8'(8'(prod10[15:11]) * 8'd10);
    assign rem26_raw = glyph - 8'(8'(prod26[15:11]) * 8'd26);
    assign rem10     = (rem10_raw >= 8'd10) ? rem10_raw - 8'd10 : rem10_raw;
    assign rem26     = (rem26_raw >= 8'd26) ? rem26_raw - 8'd26 : rem26_raw;

    assign pix_shifted  = pixels << shift;
    assign mask_shifted = mask << shift;

    always_comb
    begin
        task_out          = '0;
        task_out.column   = column;
        task_out.page     = page;
        task_out.shift    = shift;
        task_out.bits     = pix_shifted;
        task_out.clear    = '1;
        case (command)
            CMD_FILL:
            begin
                task_out.kind = K_FILL;
                task_out.bits = pixels;
            end
            CMD_SPRITE:
            begin
                task_out.kind = K_MERGE;
            end
            CMD_MASKED:
            begin
                task_out.kind  = K_MERGE;
                task_out.clear = mask_shifted;
            end
            CMD_DIGIT:
            begin
                task_out.kind     = K_GLYPH;
                task_out.letter   = 1'b0;
                task_out.rom_base = ROM_IDX_W'(rem10 * 8'd3);
            end
            CMD_LETTER:
            begin
                task_out.kind     = K_GLYPH;
                task_out.letter   = 1'b1;
                task_out.rom_base = ROM_IDX_W'(rem26 * 8'd5);
            end
            CMD_SETPOS:
            begin
                task_out.kind = K_POS;
            end
            CMD_SCAN:
            begin
                task_out.kind = K_SCAN;
            end
            default:
            begin
                task_out.kind = K_NONE;
            end
        endcase
    end

endmodule

[src/ocfb_task_q.sv]
// two-entry queue of decoded commands between decoder and executor
module ocfb_task_q (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ocfb_pkg::task_t task_in,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output ocfb_pkg::task_t task_out
);

    import ocfb_pkg::*;

    task_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign task_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= task_in;
        end
    end

endmodule

[src/ocfb_back.sv]
// executor: read-modify-write on the column store and the result byte queue
module ocfb_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        task_empty,
    input  ocfb_pkg::task_t             task_head,
    output logic                        task_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [ocfb_pkg::BYTE_W-1:0] out_byte,
    output logic                        is_data,
    output logic                        last
);

    import ocfb_pkg::*;

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int CUR_W     = COLUMN_W + 1;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_MERGE,
        S_SCAN,
        S_POS
    } state_t;

    state_t                  state_reg, state_next;
    logic [CUR_W-1:0]        cur_col_reg, cur_col_next;
    logic [PAGE_W-1:0]       page_reg, page_next;
    logic [SHIFT_W-1:0]      shift_reg, shift_next;
    logic [WORD_W-1:0]       bits_reg, bits_next;
    logic [WORD_W-1:0]       clear_reg, clear_next;
    logic                    glyph_reg, glyph_next;
    logic                    letter_reg, letter_next;
    logic [ROM_IDX_W-1:0]    rom_idx_reg, rom_idx_next;
    logic [2:0]              cnt_reg, cnt_next;
    logic [1:0]              pos_idx_reg, pos_idx_next;
    logic [WORD_W-1:0]       fill_reg, fill_next;
    logic [SCREEN_COLUMNS-1:0] valid_reg, valid_next;
    logic                    valid_rd_reg, valid_rd_next;

    result_t                 res_mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]    res_rd_reg, res_rd_next;
    logic [RES_PTR_W-1:0]    res_wr_reg, res_wr_next;
    logic [RES_PTR_W:0]      res_count_reg, res_count_next;

    logic                    rd_en;
    logic [CUR_W-1:0]        rd_col;
    logic [WORD_W-1:0]       rd_data;
    logic                    wr_en;
    logic [WORD_W-1:0]       wr_data;
    logic [WORD_W-1:0]       old_word;
    logic [WORD_W-1:0]       merge_bits;
    logic [WORD_W-1:0]       merge_clear;
    logic                    col_ok;
    logic                    res_space;
    logic                    res_push;
    logic                    res_pop;
    result_t                 res_item;

    ocfb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SCREEN_COLUMNS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cur_col_reg[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_col[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign old_word  = valid_rd_reg ? rd_data : fill_reg;
    assign col_ok    = (cur_col_reg < CUR_W'(SCREEN_COLUMNS));
    assign res_space = (res_count_reg != (RES_PTR_W+1)'(RES_DEPTH));
    assign res_pop   = pop && !empty;

    assign empty    = (res_count_reg == '0);
    assign out_byte = res_mem_reg[res_rd_reg].out_byte;
    assign is_data  = res_mem_reg[res_rd_reg].is_data;
    assign last     = res_mem_reg[res_rd_reg].last;

    always_comb
    begin
        if (glyph_reg)
        begin
            merge_bits  = WORD_W'(glyph_column(letter_reg, rom_idx_reg)) << shift_reg;
            merge_clear = WORD_W'(GLYPH_MASK) << shift_reg;
        end
        else
        begin
            merge_bits  = bits_reg;
            merge_clear = clear_reg;
        end
        wr_data = (old_word & ~merge_clear) | merge_bits;
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_col_next  = cur_col_reg;
        page_next     = page_reg;
        shift_next    = shift_reg;
        bits_next     = bits_reg;
        clear_next    = clear_reg;
        glyph_next    = glyph_reg;
        letter_next   = letter_reg;
        rom_idx_next  = rom_idx_reg;
        cnt_next      = cnt_reg;
        pos_idx_next  = pos_idx_reg;
        fill_next     = fill_reg;
        valid_next    = valid_reg;
        valid_rd_next = valid_rd_reg;
        task_pop      = 1'b0;
        rd_en         = 1'b0;
        rd_col        = cur_col_reg;
        wr_en         = 1'b0;
        res_push      = 1'b0;
        res_item      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (!task_empty)
                begin
                    task_pop     = 1'b1;
                    cur_col_next = CUR_W'(task_head.column);
                    page_next    = task_head.page;
                    shift_next   = task_head.shift;
                    bits_next    = task_head.bits;
                    clear_next   = task_head.clear;
                    letter_next  = task_head.letter;
                    rom_idx_next = task_head.rom_base;
                    glyph_next   = (task_head.kind == K_GLYPH);
                    cnt_next     = task_head.letter ? LETTER_COLS : DIGIT_COLS;
                    pos_idx_next = 2'd0;
                    rd_col       = CUR_W'(task_head.column);
                    case (task_head.kind)
                        K_FILL:
                        begin
                            fill_next  = task_head.bits;
                            valid_next = '0;
                        end
                        K_MERGE, K_GLYPH:
                        begin
                            rd_en      = 1'b1;
                            state_next = S_MERGE;
                        end
                        K_SCAN:
                        begin
                            rd_en      = 1'b1;
                            state_next = S_SCAN;
                        end
                        K_POS:
                        begin
                            state_next = S_POS;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                    if (rd_en)
                    begin
                        valid_rd_next = valid_reg[rd_col[ADDR_W-1:0]];
                    end
                end
            end
            S_MERGE:
            begin
                wr_en = col_ok;
                if (col_ok)
                begin
                    valid_next[cur_col_reg[ADDR_W-1:0]] = 1'b1;
                end
                if (glyph_reg && cnt_reg > 3'd1)
                begin
                    cur_col_next  = cur_col_reg + CUR_W'(1);
                    rom_idx_next  = rom_idx_reg + ROM_IDX_W'(1);
                    cnt_next      = cnt_reg - 3'd1;
                    rd_col        = cur_col_reg + CUR_W'(1);
                    rd_en         = 1'b1;
                    valid_rd_next = valid_reg[rd_col[ADDR_W-1:0]];
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                res_item.is_data = 1'b1;
                res_item.last    = 1'b1;
                if (col_ok && page_reg < PAGE_W'(SCREEN_PAGES))
                begin
                    res_item.out_byte = BYTE_W'(old_word >> {page_reg[1:0], 3'b000});
                end
                if (res_space)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POS:
            begin
                res_item.is_data = 1'b0;
                case (pos_idx_reg)
                    2'd0:
                    begin
                        res_item.out_byte = SETPAGE_BASE | BYTE_W'(page_reg);
                    end
                    2'd1:
                    begin
                        res_item.out_byte = BYTE_W'(cur_col_reg[3:0]);
                    end
                    default:
                    begin
                        res_item.out_byte = COLHI_BASE | BYTE_W'(cur_col_reg[7:4]);
                        res_item.last     = 1'b1;
                    end
                endcase
                if (res_space)
                begin
                    res_push     = 1'b1;
                    pos_idx_next = pos_idx_reg + 2'd1;
                    if (pos_idx_reg == 2'd2)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_wr_next    = res_push ? res_wr_reg + RES_PTR_W'(1) : res_wr_reg;
        res_rd_next    = res_pop ? res_rd_reg + RES_PTR_W'(1) : res_rd_reg;
        res_count_next = res_count_reg;
        if (res_push && !res_pop)
        begin
            res_count_next = res_count_reg + (RES_PTR_W+1)'(1);
        end
        else if (res_pop && !res_push)
        begin
            res_count_next = res_count_reg - (RES_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_col_reg   <= '0;
            page_reg      <= '0;
            shift_reg     <= '0;
            bits_reg      <= '0;
            clear_reg     <= '0;
            glyph_reg     <= 1'b0;
            letter_reg    <= 1'b0;
            rom_idx_reg   <= '0;
            cnt_reg       <= '0;
            pos_idx_reg   <= '0;
            fill_reg      <= '0;
            valid_reg     <= '0;
            valid_rd_reg  <= 1'b0;
            res_rd_reg    <= '0;
            res_wr_reg    <= '0;
            res_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            page_reg      <= page_next;
            shift_reg     <= shift_next;
            bits_reg      <= bits_next;
            clear_reg     <= clear_next;
            glyph_reg     <= glyph_next;
            letter_reg    <= letter_next;
            rom_idx_reg   <= rom_idx_next;
            cnt_reg       <= cnt_next;
            pos_idx_reg   <= pos_idx_next;
            fill_reg      <= fill_next;
            valid_reg     <= valid_next;
            valid_rd_reg  <= valid_rd_next;
            res_rd_reg    <= res_rd_next;
            res_wr_reg    <= res_wr_next;
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem_reg[res_wr_reg] <= res_item;
        end
    end

endmodule

[src/oled_column_framebuffer_blitter.sv]
// top level of the column framebuffer blitter for a 128x32 monochrome oled
// Commands enter through a two-entry queue and are carried out one at a time by an executor
// that does read-modify-write on a single column ram (one write and one registered read port).
// Fill is done as it is taken (a per-column valid bit and a fill word stand in for a sweep;
// reset clears the screen at once); a sprite column or a scan byte is read, then merged or
// queued; a digit or letter is merged one glyph column at a time; set position queues three
// command bytes. Result bytes wait in a four-entry queue; each run of bytes ends with last set.
module oled_column_framebuffer_blitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [ocfb_pkg::CMD_W-1:0]    command,
    input  logic [ocfb_pkg::COLUMN_W-1:0] column,
    input  logic [ocfb_pkg::SHIFT_W-1:0]  shift,
    input  logic [ocfb_pkg::WORD_W-1:0]   pixels,
    input  logic [ocfb_pkg::WORD_W-1:0]   mask,
    input  logic [ocfb_pkg::GLYPH_W-1:0]  glyph,
    input  logic [ocfb_pkg::PAGE_W-1:0]   page,
    input  logic                          pop,
    output logic                          empty,
    output logic [ocfb_pkg::BYTE_W-1:0]   out_byte,
    output logic                          is_data,
    output logic                          last
);

    import ocfb_pkg::*;

    task_t decoded;
    task_t task_head;
    logic  task_empty;
    logic  task_pop;

    ocfb_front u_front (
        .command  (command),
        .column   (column),
        .shift    (shift),
        .pixels   (pixels),
        .mask     (mask),
        .glyph    (glyph),
        .page     (page),
        .task_out (decoded)
    );

    ocfb_task_q u_task_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .task_in  (decoded),
        .full     (full),
        .pop      (task_pop),
        .empty    (task_empty),
        .task_out (task_head)
    );

    ocfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_empty (task_empty),
        .task_head  (task_head),
        .task_pop   (task_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .is_data    (is_data),
        .last       (last)
    );

endmodule

[src/ocfb_checker.sv]
// port-level assertions for the column framebuffer blitter and their binding
module ocfb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pop,
    input logic                          empty,
    input logic [ocfb_pkg::BYTE_W-1:0]   out_byte,
    input logic                          is_data,
    input logic                          last
);

    // a waiting result holds until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_byte) && $stable(is_data) && $stable(last))
        else $error("result changed while stalled");

    // a data byte comes only from a scan and is always the end of its run
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && is_data |-> last)
        else $error("data byte without last");

    // final command byte is the high column nibble command
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !is_data && last |-> out_byte[7:4] == 4'h1)
        else $error("bad final command byte");

    // earlier command bytes are the page command or the low column nibble
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !is_data && !last |-> out_byte[7:4] == 4'hB || out_byte[7:4] == 4'h0)
        else $error("bad leading command byte");

endmodule

bind oled_column_framebuffer_blitter ocfb_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .is_data  (is_data),
    .last     (last)
);

[tb/ocfb_tb_pkg.sv]
// scoreboard class for the column framebuffer blitter, with its own framebuffer and fonts
package ocfb_tb_pkg;

    import ocfb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    localparam logic [4:0] STROKE_DIGITS [0:29] = '{
        5'h0E, 5'h11, 5'h0E, 5'h02, 5'h1F, 5'h00, 5'h12, 5'h19, 5'h16, 5'h11,
        5'h15, 5'h0A, 5'h07, 5'h04, 5'h1F, 5'h17, 5'h15, 5'h09, 5'h0E, 5'h15,
        5'h08, 5'h01, 5'h19, 5'h07, 5'h0A, 5'h15, 5'h0A, 5'h02, 5'h15, 5'h0E
    };

    localparam logic [4:0] STROKE_LETTERS [0:129] = '{
        5'h1C, 5'h0A, 5'h09, 5'h0A, 5'h1C, 5'h1F, 5'h15, 5'h15, 5'h15, 5'h0A,
        5'h0E, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h1F, 5'h11, 5'h11, 5'h11, 5'h0E,
        5'h1F, 5'h15, 5'h15, 5'h15, 5'h11, 5'h1F, 5'h05, 5'h05, 5'h05, 5'h01,
        5'h0E, 5'h11, 5'h11, 5'h15, 5'h0D, 5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F,
        5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h08, 5'h10, 5'h11, 5'h0F, 5'h01,
        5'h1F, 5'h04, 5'h04, 5'h0A, 5'h11, 5'h1F, 5'h10, 5'h10, 5'h10, 5'h10,
        5'h1F, 5'h01, 5'h02, 5'h01, 5'h1F, 5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F,
        5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h1F, 5'h05, 5'h05, 5'h05, 5'h02,
        5'h0E, 5'h11, 5'h11, 5'h09, 5'h16, 5'h1F, 5'h05, 5'h05, 5'h05, 5'h1A,
        5'h12, 5'h15, 5'h15, 5'h15, 5'h09, 5'h01, 5'h01, 5'h1F, 5'h01, 5'h01,
        5'h0F, 5'h10, 5'h10, 5'h10, 5'h0F, 5'h03, 5'h0C, 5'h10, 5'h0C, 5'h03,
        5'h0F, 5'h10, 5'h08, 5'h10, 5'h0F, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11,
        5'h01, 5'h02, 5'h1C, 5'h02, 5'h01, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11
    };

    class frame_scoreboard;

        logic [WORD_W-1:0] frame [SCREEN_COLUMNS];
        result_t           pending_bytes [$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       draws;
        int unsigned       scans;
        int unsigned       positions;

        function new();
            foreach (frame[i])
            begin
                frame[i] = '0;
            end
            errors    = 0;
            checked   = 0;
            draws     = 0;
            scans     = 0;
            positions = 0;
        endfunction

        function void blend(int unsigned x, logic [WORD_W-1:0] bits, logic [WORD_W-1:0] clr);
            if (x < SCREEN_COLUMNS)
            begin
                frame[x] = (frame[x] & ~clr) | bits;
            end
        endfunction

        function void draw_glyph(logic [COLUMN_W-1:0] col, logic [SHIFT_W-1:0] sh,
                                 logic [GLYPH_W-1:0] code, logic letter);
            logic [WORD_W-1:0] pat;
            logic [WORD_W-1:0] clr;
            int unsigned       base;
            int unsigned       width;
            width = letter ? 5 : 3;
            base  = letter ? (code % 26) * 5 : (code % 10) * 3;
            clr   = 32'h1F << sh;
            for (int unsigned c = 0; c < width; c++)
            begin
                pat = letter ? WORD_W'(STROKE_LETTERS[base + c])
                             : WORD_W'(STROKE_DIGITS[base + c]);
                pat = pat << sh;
                blend(int'(col) + c, pat, clr);
            end
        endfunction

        // notes one accepted command and queues the bytes it should produce
        function void note_command(logic [CMD_W-1:0] cmd, logic [COLUMN_W-1:0] col,
                                   logic [SHIFT_W-1:0] sh, logic [WORD_W-1:0] pix,
                                   logic [WORD_W-1:0] msk, logic [GLYPH_W-1:0] code,
                                   logic [PAGE_W-1:0] pg);
            logic [WORD_W-1:0] shifted;
            result_t           r;
            shifted = pix << sh;
            case (cmd)
                CMD_FILL:
                begin
                    foreach (frame[i])
                    begin
                        frame[i] = pix;
                    end
                    draws++;
                end
                CMD_SPRITE:
                begin
                    blend(32'(col), shifted, '1);
                    draws++;
                end
                CMD_MASKED:
                begin
                    blend(32'(col), shifted, msk << sh);
                    draws++;
                end
                CMD_DIGIT:
                begin
                    draw_glyph(col, sh, code, 1'b0);
                    draws++;
                end
                CMD_LETTER:
                begin
                    draw_glyph(col, sh, code, 1'b1);
                    draws++;
                end
                CMD_SETPOS:
                begin
                    r = '{out_byte: SETPAGE_BASE | {4'h0, pg}, is_data: 1'b0, last: 1'b0};
                    pending_bytes.push_back(r);
                    r = '{out_byte: {4'h0, col[3:0]}, is_data: 1'b0, last: 1'b0};
                    pending_bytes.push_back(r);
                    r = '{out_byte: COLHI_BASE | {4'h0, col[7:4]}, is_data: 1'b0, last: 1'b1};
                    pending_bytes.push_back(r);
                    positions++;
                end
                CMD_SCAN:
                begin
                    r = '{out_byte: 8'h00, is_data: 1'b1, last: 1'b1};
                    if (col < SCREEN_COLUMNS && pg < SCREEN_PAGES)
                    begin
                        r.out_byte = frame[col][pg * 8 +: 8];
                    end
                    pending_bytes.push_back(r);
                    scans++;
                end
                default:
                begin
                end
            endcase
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            $display("%0t ns  %s: got %0h, expected %0h", $time, what, got, want);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (pending_bytes.size() == 0)
            begin
                report("byte with nothing outstanding", 32'(got.out_byte), 0);
                return;
            end
            want = pending_bytes.pop_front();
            checked++;
            if (got.out_byte !== want.out_byte)
            begin
                report("out_byte", 32'(got.out_byte), 32'(want.out_byte));
            end
            if (got.is_data !== want.is_data)
            begin
                report("is_data", 32'(got.is_data), 32'(want.is_data));
            end
            if (got.last !== want.last)
            begin
                report("last", 32'(got.last), 32'(want.last));
            end
        endtask

        function int unsigned outstanding();
            return pending_bytes.size();
        endfunction

    endclass

endpackage

[tb/tb_top.sv]
// top-level testbench of the column framebuffer blitter
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ocfb_pkg::*;
    import ocfb_tb_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [CMD_W-1:0]    command = '0;
    logic [COLUMN_W-1:0] column = '0;
    logic [SHIFT_W-1:0]  shift = '0;
    logic [WORD_W-1:0]   pixels = '0;
    logic [WORD_W-1:0]   mask = '0;
    logic [GLYPH_W-1:0]  glyph = '0;
    logic [PAGE_W-1:0]   page = '0;
    logic                pop = 1'b0;
    logic                empty;
    logic [BYTE_W-1:0]   out_byte;
    logic                is_data;
    logic                last;

    frame_scoreboard sb = new();
    int unsigned     sent = 0;
    int unsigned     burst_left = 0;
    bit              hold_request = 1'b0;
    int unsigned     recent_column = 0;

    oled_column_framebuffer_blitter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .command  (command),
        .column   (column),
        .shift    (shift),
        .pixels   (pixels),
        .mask     (mask),
        .glyph    (glyph),
        .page     (page),
        .pop      (pop),
        .empty    (empty),
        .out_byte (out_byte),
        .is_data  (is_data),
        .last     (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2ms;
        $display("oled_column_framebuffer_blitter: mismatch");
        $finish;
    end

    function automatic int unsigned sender_gap();
        if (burst_left > 0 || (sent / 30) % 3 == 2)
        begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // one command transfer, preceded by a random gap except in back-to-back stretches
    task automatic run_command(input logic [CMD_W-1:0] cmd, input logic [COLUMN_W-1:0] col,
                               input logic [SHIFT_W-1:0] sh, input logic [WORD_W-1:0] pix,
                               input logic [WORD_W-1:0] msk, input logic [GLYPH_W-1:0] code,
                               input logic [PAGE_W-1:0] pg);
        int unsigned gap;
        gap = sender_gap();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        command <= cmd;
        column  <= col;
        shift   <= sh;
        pixels  <= pix;
        mask    <= msk;
        glyph   <= code;
        page    <= pg;
        @(negedge clk);
        while (full)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        sb.note_command(cmd, col, sh, pix, msk, code, pg);
        sent++;
    endtask

    task automatic random_command();
        logic [CMD_W-1:0]    cmd;
        logic [COLUMN_W-1:0] col;
        logic [PAGE_W-1:0]   pg;
        int unsigned         sel;
        sel = $urandom_range(0, 99);
        col = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                          : 8'($urandom_range(0, 127));
        if (burst_left > 0)
        begin
            cmd = (sel < 50) ? CMD_SCAN : CMD_SETPOS;
        end
        else if (sel < 3)
        begin
            cmd = CMD_FILL;
        end
        else if (sel < 15)
        begin
            cmd = CMD_SPRITE;
        end
        else if (sel < 30)
        begin
            cmd = CMD_MASKED;
        end
        else if (sel < 42)
        begin
            cmd = CMD_DIGIT;
        end
        else if (sel < 54)
        begin
            cmd = CMD_LETTER;
        end
        else if (sel < 66)
        begin
            cmd = CMD_SETPOS;
        end
        else if (sel < 98)
        begin
            cmd = CMD_SCAN;
        end
        else
        begin
            cmd = CMD_UNUSED;
        end
        // some glyphs go near the right edge, where they can be clipped
        if ((cmd == CMD_DIGIT || cmd == CMD_LETTER) && $urandom_range(0, 4) == 0)
        begin
            col = 8'($urandom_range(122, 127));
        end
        // read back what was drawn lately
        if (cmd == CMD_SCAN && $urandom_range(0, 1) == 1)
        begin
            col = 8'(recent_column);
        end
        if (cmd == CMD_SCAN)
        begin
            pg = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(4, 15))
                                             : 4'($urandom_range(0, 3));
        end
        else
        begin
            pg = 4'($urandom_range(0, 15));
        end
        if (cmd == CMD_DIGIT || cmd == CMD_LETTER)
        begin
            recent_column = col + $urandom_range(0, (cmd == CMD_DIGIT) ? 2 : 4);
        end
        else if (cmd == CMD_SPRITE || cmd == CMD_MASKED)
        begin
            recent_column = col;
        end
        run_command(cmd, col, 5'($urandom_range(0, 31)), $urandom, $urandom,
                    8'($urandom_range(0, 255)), pg);
    endtask

    // result side: random pop gaps with gap-free stretches, plus one long hold when asked for
    initial
    begin
        int unsigned gap;
        int unsigned popped;
        result_t     got;
        popped = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (300) @(posedge clk);
                hold_request = 1'b0;
            end
            gap = ((popped / 25) % 3 == 1) ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(negedge clk);
            while (empty)
            begin
                @(negedge clk);
            end
            got = '{out_byte: out_byte, is_data: is_data, last: last};
            @(posedge clk);
            sb.check_result(got);
            popped++;
        end
    end

    initial
    begin
        int unsigned counted;
        wait (rst_n);
        @(posedge clk);

        // empty screen, then all ones and reads around the edges, then every command kind and read-backs
        run_command(CMD_SCAN,   8'd0,   5'd0,  '0, '0, 8'd0, 4'd0);
        run_command(CMD_FILL,   8'd0,   5'd0,  32'hFFFF_FFFF, '0, 8'd0, 4'd0);
        run_command(CMD_SCAN,   8'd127, 5'd0,  '0, '0, 8'd0, 4'd3);
        run_command(CMD_SCAN,   8'd128, 5'd0,  '0, '0, 8'd0, 4'd0);
        run_command(CMD_SCAN,   8'd5,   5'd0,  '0, '0, 8'd0, 4'd4);
        run_command(CMD_SCAN,   8'd255, 5'd31, '1, '1, 8'd255, 4'd15);
        run_command(CMD_SPRITE, 8'd0,   5'd0,  32'hA5A5_5A5A, '0, 8'd0, 4'd0);
        run_command(CMD_SPRITE, 8'd127, 5'd31, 32'hFFFF_FFFF, '1, 8'd0, 4'd0);
        run_command(CMD_SPRITE, 8'd128, 5'd0,  32'h0000_0000, '0, 8'd0, 4'd0);
        run_command(CMD_MASKED, 8'd1,   5'd4,  32'h0000_00F0, 32'hFFFF_FFFF, 8'd0, 4'd0);
        run_command(CMD_MASKED, 8'd2,   5'd0,  32'h0000_0000, 32'h0000_0000, 8'd0, 4'd0);
        run_command(CMD_DIGIT,  8'd10,  5'd0,  '0, '0, 8'd0, 4'd0);
        run_command(CMD_DIGIT,  8'd20,  5'd27, '0, '0, 8'd255, 4'd0);
        run_command(CMD_LETTER, 8'd30,  5'd8,  '0, '0, 8'd25, 4'd0);
        run_command(CMD_LETTER, 8'd125, 5'd3,  '0, '0, 8'd255, 4'd0);
        run_command(CMD_SETPOS, 8'd0,   5'd0,  '0, '0, 8'd0, 4'd0);
        run_command(CMD_SETPOS, 8'd255, 5'd31, '1, '1, 8'd255, 4'd15);
        run_command(CMD_UNUSED, 8'd3,   5'd0,  '1, '1, 8'd0, 4'd0);
        run_command(CMD_SCAN,   8'd0,   5'd0,  '0, '0, 8'd0, 4'd2);
        run_command(CMD_SCAN,   8'd1,   5'd0,  '0, '0, 8'd0, 4'd0);
        run_command(CMD_SCAN,   8'd3,   5'd0,  '0, '0, 8'd0, 4'd1);
        run_command(CMD_SCAN,   8'd11,  5'd0,  '0, '0, 8'd0, 4'd0);
        run_command(CMD_SCAN,   8'd20,  5'd0,  '0, '0, 8'd0, 4'd3);
        run_command(CMD_SCAN,   8'd32,  5'd0,  '0, '0, 8'd0, 4'd1);
        run_command(CMD_SCAN,   8'd127, 5'd0,  '0, '0, 8'd0, 4'd0);

        counted = 0;
        while (counted < 390)
        begin
            if (counted == 150)
            begin
                hold_request = 1'b1;
                burst_left   = 40;
            end
            random_command();
            if (command != CMD_UNUSED)
            begin
                counted++;
            end
        end
        push <= 1'b0;

        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        $display("ran %0d commands: %0d drawing, %0d page reads, %0d cursor moves",
                 sent, sb.draws, sb.scans, sb.positions);
        $display("compared %0d output bytes, %0d field errors", sb.checked, sb.errors);
        if (sb.errors == 0)
        begin
            $display("oled_column_framebuffer_blitter: match");
        end
        else
        begin
            $display("oled_column_framebuffer_blitter: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
src/ocfb_pkg.sv
src/ocfb_ram.sv
src/ocfb_front.sv
src/ocfb_task_q.sv
src/ocfb_back.sv
src/oled_column_framebuffer_blitter.sv
src/ocfb_checker.sv
tb/ocfb_tb_pkg.sv
tb/tb_top.sv
